### rtl/core/mss_pkg.sv
// Shared types and constants for the masked signature sniffer.
// Used by masked_signature_type_sniffer and mss_checker; no dependencies.
package mss_pkg;

    // Field widths of the word on each channel
    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int IDX_W    = 4;
    localparam int LEN_W    = 5;
    localparam int FMT_W    = 16;
    localparam int STATUS_W = 2;

    // Byte positions a signature entry can hold (addressed by byte_index)
    localparam int SLOT_BYTES = 16;
    localparam int SLOT_W     = 4;

    // Word kinds on the input channel (code 3 is unused)
    typedef enum logic [KIND_W-1:0] {
        KIND_SNIFF = 2'd0,
        KIND_SIG   = 2'd1,
        KIND_HDR   = 2'd2
    } kind_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_MATCH   = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_MORE    = 2'd2
    } status_t;

endpackage

### rtl/core/masked_signature_type_sniffer.sv
// Masked signature sniffer: per-entry mask/pattern table, parallel byte test, report.
// Depends on mss_pkg.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in      | input     | in_valid / in_ready   | kind, data_byte, mask_byte, last_byte,
//           |           |                      | stream_ended, entry_index, byte_index,
//           |           |                      | entry_length, entry_format, entry_enable
//   out     | output    | out_valid / out_ready | status, format_code, matched_entry
//
// One word per cycle while the output is not stalled. A word is held in the input register,
// is tested against every entry in parallel, and its result (last sniff byte only) is
// loaded into the output register when that register can take it; out_valid then rises.
// A stalled result holds in the output register; the input register still takes one more
// word, and in_ready drops only while both registers are full and out_ready is low.
// Reset clears entry-present bits and the byte counter and sets all alive flags; the mask,
// pattern, length and format tables are not reset.
module masked_signature_type_sniffer #(
    parameter int NUM_SIGS  = 16,
    parameter int SIG_BYTES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mss_pkg::KIND_W-1:0]    kind,
    input  logic [mss_pkg::BYTE_W-1:0]    data_byte,
    input  logic [mss_pkg::BYTE_W-1:0]    mask_byte,
    input  logic                          last_byte,
    input  logic                          stream_ended,
    input  logic [mss_pkg::IDX_W-1:0]     entry_index,
    input  logic [mss_pkg::IDX_W-1:0]     byte_index,
    input  logic [mss_pkg::LEN_W-1:0]     entry_length,
    input  logic [mss_pkg::FMT_W-1:0]     entry_format,
    input  logic                          entry_enable,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mss_pkg::STATUS_W-1:0]  status,
    output logic [mss_pkg::FMT_W-1:0]     format_code,
    output logic [mss_pkg::IDX_W-1:0]     matched_entry
);
    import mss_pkg::*;

    localparam int CNT_W = $clog2(SIG_BYTES + 1);

    // Input register
    logic               in_v_reg;
    kind_t              kind_reg;
    logic [BYTE_W-1:0]  data_reg;
    logic [BYTE_W-1:0]  mask_in_reg;
    logic               last_reg;
    logic               ended_reg;
    logic [IDX_W-1:0]   eidx_reg;
    logic [IDX_W-1:0]   bidx_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [FMT_W-1:0]   fmt_reg;
    logic               en_reg;

    // Signature table
    logic [BYTE_W-1:0]  mask_reg [NUM_SIGS][SLOT_BYTES];
    logic [BYTE_W-1:0]  pat_reg  [NUM_SIGS][SLOT_BYTES];
    logic [LEN_W-1:0]   len_store_reg [NUM_SIGS];
    logic [FMT_W-1:0]   fmt_store_reg [NUM_SIGS];
    logic [NUM_SIGS-1:0] present_reg;

    // Header scan state
    logic [NUM_SIGS-1:0] alive_reg;
    logic [CNT_W-1:0]    cnt_reg;

    // Output register
    logic               out_v_reg;
    status_t            status_reg;
    logic [FMT_W-1:0]   fmt_out_reg;
    logic [IDX_W-1:0]   idx_out_reg;

    logic               advance;
    logic               is_sniff;
    logic               is_sig;
    logic               is_hdr;
    logic               sig_wr;
    logic               hdr_wr;
    logic               cnt_open;
    logic [SLOT_W-1:0]  slot_idx;
    logic [NUM_SIGS-1:0] dies;
    logic [NUM_SIGS-1:0] alive_next;
    logic [CNT_W-1:0]    cnt_next;
    logic [LEN_W-1:0]    len_sat;
    logic               found;
    logic               any_live;
    logic [FMT_W-1:0]   hit_fmt;
    logic [IDX_W-1:0]   hit_idx;
    status_t            status_next;

    // Handshake: process the held word whenever the output register can take a result
    assign advance  = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready = !in_v_reg || advance;

    // Kind decode
    always_comb
    begin
        is_sniff = 1'b0;
        is_sig   = 1'b0;
        is_hdr   = 1'b0;
        unique case (kind_reg)
            KIND_SNIFF: is_sniff = 1'b1;
            KIND_SIG:   is_sig   = 1'b1;
            KIND_HDR:   is_hdr   = 1'b1;
            default:    ;
        endcase
    end

    assign sig_wr  = advance && is_sig && (int'(bidx_reg) < SIG_BYTES);
    assign hdr_wr  = advance && is_hdr;
    assign len_sat = (len_reg > LEN_W'(SLOT_BYTES)) ? LEN_W'(SLOT_BYTES) : len_reg;

    // Parallel byte test at the current header position
    assign cnt_open = cnt_reg < CNT_W'(SIG_BYTES);
    assign slot_idx = SLOT_W'(cnt_reg);

    always_comb
    begin
        for (int e = 0; e < NUM_SIGS; e++)
        begin
            dies[e] = present_reg[e] && alive_reg[e] && cnt_open
                      && (int'(cnt_reg) < int'(len_store_reg[e]))
                      && ((data_reg & mask_reg[e][slot_idx]) != pat_reg[e][slot_idx]);
        end
    end

    assign alive_next = alive_reg & ~dies;
    assign cnt_next   = cnt_open ? cnt_reg + CNT_W'(1) : cnt_reg;

    // Report: lowest live entry whose length is covered
    always_comb
    begin
        found    = 1'b0;
        any_live = 1'b0;
        hit_fmt  = '0;
        hit_idx  = '0;
        for (int e = 0; e < NUM_SIGS; e++)
        begin
            if (present_reg[e] && alive_next[e])
            begin
                any_live = 1'b1;
                if (!found && (int'(len_store_reg[e]) <= int'(cnt_next)))
                begin
                    found   = 1'b1;
                    hit_fmt = fmt_store_reg[e];
                    hit_idx = IDX_W'(e);
                end
            end
        end
        priority if (found)
            status_next = ST_MATCH;
        else if (any_live && !ended_reg)
            status_next = ST_MORE;
        else
            status_next = ST_NOMATCH;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
            present_reg <= '0;
            alive_reg   <= '1;
            cnt_reg     <= '0;
        end
        else
        begin
            if (in_ready)
                in_v_reg <= in_valid;

            if (advance && is_sniff && last_reg)
                out_v_reg <= 1'b1;
            else if (out_ready)
                out_v_reg <= 1'b0;

            if (advance && is_sniff)
            begin
                alive_reg <= last_reg ? '1 : alive_next;
                cnt_reg   <= last_reg ? '0 : cnt_next;
            end

            if (hdr_wr)
            begin
                for (int e = 0; e < NUM_SIGS; e++)
                begin
                    if (int'(eidx_reg) == e)
                        present_reg[e] <= en_reg && (len_reg != '0);
                end
            end
        end
    end

    // Input payload register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg    <= kind_t'(kind);
            data_reg    <= data_byte;
            mask_in_reg <= mask_byte;
            last_reg    <= last_byte;
            ended_reg   <= stream_ended;
            eidx_reg    <= entry_index;
            bidx_reg    <= byte_index;
            len_reg     <= entry_length;
            fmt_reg     <= entry_format;
            en_reg      <= entry_enable;
        end
    end

    // Signature table writes
    always_ff @(posedge clk)
    begin
        for (int e = 0; e < NUM_SIGS; e++)
        begin
            if (sig_wr && (int'(eidx_reg) == e))
            begin
                mask_reg[e][bidx_reg] <= mask_in_reg;
                pat_reg[e][bidx_reg]  <= data_reg;
            end
            if (hdr_wr && (int'(eidx_reg) == e) && en_reg && (len_reg != '0))
            begin
                len_store_reg[e] <= len_sat;
                fmt_store_reg[e] <= fmt_reg;
            end
        end
    end

    // Result payload register
    always_ff @(posedge clk)
    begin
        if (advance && is_sniff && last_reg)
        begin
            status_reg  <= status_next;
            fmt_out_reg <= hit_fmt;
            idx_out_reg <= hit_idx;
        end
    end

    assign out_valid     = out_v_reg;
    assign status        = status_reg;
    assign format_code   = fmt_out_reg;
    assign matched_entry = idx_out_reg;

endmodule

### rtl/core/mss_checker.sv
// Port-level checks for masked_signature_type_sniffer, attached by bind.
// Depends on mss_pkg.
module mss_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [mss_pkg::STATUS_W-1:0]  status,
    input logic [mss_pkg::FMT_W-1:0]     format_code,
    input logic [mss_pkg::IDX_W-1:0]     matched_entry
);
    import mss_pkg::*;

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_MATCH || status == ST_NOMATCH || status == ST_MORE))
        else $error("undefined status code");

    // Format and index are zero unless a match is reported
    a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_MATCH) |-> (format_code == '0 && matched_entry == '0))
        else $error("nonzero format or entry without a match");

    // Input side stalls only while a result is held back
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output backpressure");

    // A refused result stays with its word unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status)
            && $stable(format_code) && $stable(matched_entry)))
        else $error("result dropped or changed under stall");

endmodule

bind masked_signature_type_sniffer mss_checker u_mss_checker (.*);

### tb/masked_signature_type_sniffer_tb.sv
// Self-checking testbench for masked_signature_type_sniffer: loads signature tables,
// streams header bytes under several idling patterns and checks every report in order.
// Depends on mss_pkg and the masked_signature_type_sniffer RTL; nothing else.
module masked_signature_type_sniffer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mss_pkg::*;

    localparam int NUM_SIGS   = 16;
    localparam int SIG_BYTES  = 16;
    localparam int CYCLE_CAP  = 300000;
    localparam int TAIL_WAIT  = 8;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // One input word, field by field
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] mask;
        logic              last;
        logic              ended;
        logic [IDX_W-1:0]  ent;
        logic [IDX_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
        logic [FMT_W-1:0]  fmt;
        logic              en;
    } word_t;

    // One sniff report
    typedef struct {
        status_t          status;
        logic [FMT_W-1:0] fmt;
        logic [IDX_W-1:0] ent;
    } verdict_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [KIND_W-1:0]    kind = '0;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic [BYTE_W-1:0]    mask_byte = '0;
    logic                 last_byte = 1'b0;
    logic                 stream_ended = 1'b0;
    logic [IDX_W-1:0]     entry_index = '0;
    logic [IDX_W-1:0]     byte_index = '0;
    logic [LEN_W-1:0]     entry_length = '0;
    logic [FMT_W-1:0]     entry_format = '0;
    logic                 entry_enable = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [FMT_W-1:0]     format_code;
    logic [IDX_W-1:0]     matched_entry;

    masked_signature_type_sniffer #(
        .NUM_SIGS  (NUM_SIGS),
        .SIG_BYTES (SIG_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .data_byte     (data_byte),
        .mask_byte     (mask_byte),
        .last_byte     (last_byte),
        .stream_ended  (stream_ended),
        .entry_index   (entry_index),
        .byte_index    (byte_index),
        .entry_length  (entry_length),
        .entry_format  (entry_format),
        .entry_enable  (entry_enable),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .format_code   (format_code),
        .matched_entry (matched_entry)
    );

    always #6 clk = ~clk;

    // Words waiting to be driven, and reports waiting to arrive
    word_t    word_q[$];
    verdict_t verdict_q[$];

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_goal     = 0;
    int held_cycles   = 0;
    int cycle_cnt     = 0;
    int errors        = 0;
    int words_in      = 0;
    int gen_count     = 0;
    int n_match       = 0;
    int n_more        = 0;
    int n_nomatch     = 0;

    // Predicted sniffer state, updated in acceptance order
    logic [BYTE_W-1:0] sig_mask[NUM_SIGS][SLOT_BYTES];
    logic [BYTE_W-1:0] sig_pat[NUM_SIGS][SLOT_BYTES];
    logic [LEN_W-1:0]  sig_len[NUM_SIGS];
    logic [FMT_W-1:0]  sig_fmt[NUM_SIGS];
    bit   [NUM_SIGS-1:0] sig_present = '0;
    logic [NUM_SIGS-1:0] alive = '1;
    logic [LEN_W-1:0]    hdr_pos = '0;

    // Generator's view of the table, so headers can be built to match
    logic [BYTE_W-1:0] g_mask[NUM_SIGS][SLOT_BYTES];
    logic [BYTE_W-1:0] g_pat[NUM_SIGS][SLOT_BYTES];
    bit                g_written[NUM_SIGS][SLOT_BYTES];
    int                g_len[NUM_SIGS];
    bit                g_present[NUM_SIGS];

    // Apply one accepted word to the predicted state; report on the last sniff byte
    task automatic sniff_predict(input word_t w, output bit has, output verdict_t v);
        bit pending;
        has      = 1'b0;
        pending  = 1'b0;
        v.status = ST_NOMATCH;
        v.fmt    = '0;
        v.ent    = '0;
        case (w.kind)
            KIND_SIG: begin
                sig_mask[w.ent][w.pos] = w.mask;
                sig_pat[w.ent][w.pos]  = w.data;
            end
            KIND_HDR: begin
                if (w.en && w.len != 0) begin
                    sig_len[w.ent]     = (w.len > SLOT_BYTES) ? LEN_W'(SLOT_BYTES) : w.len;
                    sig_fmt[w.ent]     = w.fmt;
                    sig_present[w.ent] = 1'b1;
                end else begin
                    sig_present[w.ent] = 1'b0;
                end
            end
            KIND_SNIFF: begin
                // bytes past the signature window are not tested
                if (hdr_pos < SIG_BYTES) begin
                    for (int e = 0; e < NUM_SIGS; e++)
                        if (sig_present[e] && alive[e] && hdr_pos < sig_len[e] &&
                            (w.data & sig_mask[e][hdr_pos]) != sig_pat[e][hdr_pos])
                            alive[e] = 1'b0;
                    hdr_pos++;
                end
                if (w.last) begin
                    has = 1'b1;
                    // lowest live entry fully matched wins
                    for (int e = 0; e < NUM_SIGS; e++) begin
                        if (sig_present[e] && alive[e]) begin
                            if (sig_len[e] <= hdr_pos) begin
                                v.status = ST_MATCH;
                                v.fmt    = sig_fmt[e];
                                v.ent    = IDX_W'(e);
                                pending  = 1'b0;
                                break;
                            end
                            pending = 1'b1;
                        end
                    end
                    if (v.status != ST_MATCH && pending && !w.ended)
                        v.status = ST_MORE;
                    alive   = '1;
                    hdr_pos = '0;
                end
            end
            default: ;
        endcase
    endtask

    function automatic word_t rand_word();
        word_t w;
        w.kind  = KIND_W'($urandom_range(0, 2));
        w.data  = BYTE_W'($urandom());
        w.mask  = BYTE_W'($urandom());
        w.last  = 1'($urandom_range(0, 1));
        w.ended = 1'($urandom_range(0, 1));
        w.ent   = IDX_W'($urandom());
        w.pos   = IDX_W'($urandom());
        w.len   = LEN_W'($urandom());
        w.fmt   = FMT_W'($urandom());
        w.en    = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Queue a word and keep the generator's table view current
    task automatic push_word(input word_t w);
        word_q.push_back(w);
        if (w.kind != KIND_UNUSED)
            gen_count++;
        if (w.kind == KIND_SIG) begin
            g_mask[w.ent][w.pos]    = w.mask;
            g_pat[w.ent][w.pos]     = w.data;
            g_written[w.ent][w.pos] = 1'b1;
        end else if (w.kind == KIND_HDR) begin
            if (w.en && w.len != 0) begin
                g_len[w.ent]     = (w.len > SLOT_BYTES) ? SLOT_BYTES : w.len;
                g_present[w.ent] = 1'b1;
            end else begin
                g_present[w.ent] = 1'b0;
            end
        end
    endtask

    task automatic push_sig_val(input int e, input int p, input logic [7:0] m,
                                input logic [7:0] pat);
        word_t w;
        w      = rand_word();
        w.kind = KIND_SIG;
        w.ent  = IDX_W'(e);
        w.pos  = IDX_W'(p);
        w.mask = m;
        w.data = pat;
        push_word(w);
    endtask

    task automatic push_hdr(input int e, input int len, input logic [15:0] f, input bit en);
        word_t w;
        w      = rand_word();
        w.kind = KIND_HDR;
        w.ent  = IDX_W'(e);
        w.len  = LEN_W'(len);
        w.fmt  = f;
        w.en   = en;
        push_word(w);
    endtask

    task automatic push_sniff(input logic [7:0] d, input bit last, input bit ended);
        word_t w;
        w       = rand_word();
        w.kind  = KIND_SNIFF;
        w.data  = d;
        w.last  = last;
        w.ended = ended;
        push_word(w);
    endtask

    // Signature byte with a random mask style; mostly a pattern that can match
    task automatic push_sig(input int e, input int p);
        int          r;
        logic [7:0]  m;
        logic [7:0]  pat;
        r = $urandom_range(0, 99);
        if (r < 30)
            m = 8'hFF;
        else if (r < 45)
            m = 8'h00;
        else
            m = BYTE_W'($urandom());
        pat = BYTE_W'($urandom());
        if ($urandom_range(0, 99) >= 5)
            pat = pat & m;
        push_sig_val(e, p, m, pat);
    endtask

    // Random traffic: table updates, noise and mostly well-formed headers
    task automatic run_random(input int n);
        int         start;
        int         r;
        int         e;
        int         len;
        int         eff;
        int         tgt;
        int         n_b;
        bit         rewrite;
        logic [7:0] d;
        word_t      w;
        start = gen_count;
        while (gen_count - start < n) begin
            r = $urandom_range(0, 99);
            e = $urandom_range(0, NUM_SIGS - 1);
            if (r < 14) begin
                // enable an entry; every tested position is written first
                r = $urandom_range(0, 99);
                if (r < 80)
                    len = $urandom_range(1, 6);
                else if (r < 95)
                    len = $urandom_range(7, 16);
                else
                    len = $urandom_range(17, 31);
                eff = (len > SLOT_BYTES) ? SLOT_BYTES : len;
                rewrite = ($urandom_range(0, 99) < 30);
                for (int p = 0; p < eff; p++)
                    if (rewrite || !g_written[e][p])
                        push_sig(e, p);
                push_hdr(e, len, FMT_W'($urandom()), 1'b1);
            end else if (r < 18) begin
                // removal: zero length or enable low
                len = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 31);
                push_hdr(e, len, FMT_W'($urandom()),
                         (len == 0) ? 1'($urandom_range(0, 1)) : 1'b0);
            end else if (r < 20) begin
                push_sig(e, $urandom_range(0, SLOT_BYTES - 1));
            end else if (r < 22) begin
                w      = rand_word();
                w.kind = KIND_UNUSED;
                push_word(w);
            end else begin
                // header aimed at a present entry, a few bytes short or long
                tgt = -1;
                for (int t = 0; t < 8; t++) begin
                    e = $urandom_range(0, NUM_SIGS - 1);
                    if (tgt < 0 && g_present[e])
                        tgt = e;
                end
                if (tgt >= 0)
                    n_b = g_len[tgt] + $urandom_range(0, 5) - 2;
                else
                    n_b = $urandom_range(1, 6);
                if (n_b < 1)
                    n_b = 1;
                if ($urandom_range(0, 99) < 8)
                    n_b = $urandom_range(SIG_BYTES + 1, SIG_BYTES + 4);
                for (int p = 0; p < n_b; p++) begin
                    d = BYTE_W'($urandom());
                    if (tgt >= 0 && p < SLOT_BYTES && $urandom_range(0, 99) >= 6)
                        d = g_pat[tgt][p] | (d & ~g_mask[tgt][p]);
                    push_sniff(d, p == n_b - 1, 1'($urandom_range(0, 1)));
                    if (p != n_b - 1 && $urandom_range(0, 99) < 5)
                        push_sig($urandom_range(0, NUM_SIGS - 1),
                                 $urandom_range(0, SLOT_BYTES - 1));
                end
            end
        end
    endtask

    // Wait until every word is taken and every report is in, then let the pipe settle
    task automatic drain();
        while (word_q.size() != 0 || in_valid || verdict_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_WAIT) @(negedge clk);
    endtask

    // Sender: next word only once the current one is taken
    always @(posedge clk or negedge rst_n) begin
        word_t w;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (word_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                w = word_q.pop_front();
                kind         <= w.kind;
                data_byte    <= w.data;
                mask_byte    <= w.mask;
                last_byte    <= w.last;
                stream_ended <= w.ended;
                entry_index  <= w.ent;
                byte_index   <= w.pos;
                entry_length <= w.len;
                entry_format <= w.fmt;
                entry_enable <= w.en;
                in_valid     <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: long hold-off when requested, random stalls otherwise
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (held_cycles < hold_goal) begin
            out_ready   <= 1'b0;
            held_cycles <= held_cycles + 1;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Monitor: check reports against the oldest prediction, then predict new words
    always @(posedge clk) begin
        word_t    w;
        verdict_t v;
        bit       has;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t ns: unexpected report: expected none, got %0d %h %0d",
                             $time, status, format_code, matched_entry);
                    errors++;
                end else begin
                    v = verdict_q.pop_front();
                    if (status !== v.status) begin
                        $display("%0t ns: status mismatch: expected %0d, got %0d",
                                 $time, v.status, status);
                        errors++;
                    end
                    if (format_code !== v.fmt) begin
                        $display("%0t ns: format_code mismatch: expected %h, got %h",
                                 $time, v.fmt, format_code);
                        errors++;
                    end
                    if (matched_entry !== v.ent) begin
                        $display("%0t ns: matched_entry mismatch: expected %0d, got %0d",
                                 $time, v.ent, matched_entry);
                        errors++;
                    end
                    case (v.status)
                        ST_MATCH: n_match++;
                        ST_MORE:  n_more++;
                        default:  n_nomatch++;
                    endcase
                end
            end
            if (in_valid && in_ready) begin
                w.kind  = kind;
                w.data  = data_byte;
                w.mask  = mask_byte;
                w.last  = last_byte;
                w.ended = stream_ended;
                w.ent   = entry_index;
                w.pos   = byte_index;
                w.len   = entry_length;
                w.fmt   = entry_format;
                w.en    = entry_enable;
                sniff_predict(w, has, v);
                if (has)
                    verdict_q.push_back(v);
                words_in++;
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("masked_signature_type_sniffer_tb failed");
            $finish;
        end
    end

    initial begin
        word_t w;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: two-byte signature on entry 0, catch-all on entry 15
        push_sig_val(0, 0, 8'hFF, 8'h89);
        push_sig_val(0, 1, 8'hF0, 8'h50);
        push_hdr(0, 2, 16'hFFFF, 1'b1);
        push_sniff(8'h89, 1'b0, 1'b0);
        push_sniff(8'h5F, 1'b1, 1'b0);      // masked match on entry 0
        push_sniff(8'h89, 1'b1, 1'b0);      // short header, more wanted
        push_sniff(8'h89, 1'b1, 1'b1);      // short header, stream over
        push_sniff(8'h00, 1'b1, 1'b0);      // first byte kills entry 0
        w      = rand_word();
        w.kind = KIND_UNUSED;
        w.last = 1'b1;
        push_word(w);                       // unused kind: no report
        push_sig_val(15, 0, 8'h00, 8'h00);
        push_hdr(15, 1, 16'h0000, 1'b1);
        push_sniff(8'hFF, 1'b1, 1'b1);      // only the catch-all survives
        push_sniff(8'h89, 1'b1, 1'b0);      // entry 0 pending, entry 15 reported
        push_sniff(8'h89, 1'b0, 1'b0);
        push_sniff(8'h50, 1'b1, 1'b0);      // both match, lower index wins
        push_hdr(15, 0, 16'h1234, 1'b1);    // zero length removes entry 15
        push_sniff(8'h12, 1'b1, 1'b0);
        push_hdr(0, 2, 16'h0000, 1'b0);     // enable low removes entry 0
        push_sniff(8'h89, 1'b1, 1'b0);
        drain();

        // Random phases with different idling
        run_random(250);
        drain();
        send_idle_pct = 70;
        run_random(250);
        drain();

        // Receiver held off while the sender keeps pushing
        send_idle_pct = 0;
        hold_goal     = held_cycles + 120;
        run_random(80);
        drain();

        send_idle_pct = 0;
        stall_pct     = 70;
        run_random(250);
        drain();
        send_idle_pct = 31;
        stall_pct     = 31;
        run_random(250);
        drain();

        $display("Run covered %0d input words and %0d reports",
                 words_in, n_match + n_more + n_nomatch);
        $display("(%0d match, %0d need-more, %0d no-match) under no idling, sender idle,",
                 n_match, n_more, n_nomatch);
        $display("receiver stalls, both, plus one long receiver hold-off");
        if (errors == 0)
            $display("masked_signature_type_sniffer_tb passed");
        else
            $display("masked_signature_type_sniffer_tb failed");
        $finish;
    end

endmodule

### masked_signature_type_sniffer.f
rtl/core/mss_pkg.sv
rtl/core/masked_signature_type_sniffer.sv
rtl/core/mss_checker.sv
tb/masked_signature_type_sniffer_tb.sv
